[hdl/dta_pkg.sv]
`timescale 1ns / 1ps
// Package for the descriptor table allocator: opcode and status codes,
// default sizes and the request and response transaction structs.
// Depends on nothing; the core imports it.
package dta_pkg;

   localparam int SLOT_COUNT_DEF   = 256;
   localparam int OBJECT_COUNT_DEF = 256;
   localparam int RESERVED_LOW_DEF = 3;

   localparam int MAP_BITS = 64;

   localparam logic [2:0] OP_ALLOC      = 3'd0;
   localparam logic [2:0] OP_INSTALL    = 3'd1;
   localparam logic [2:0] OP_LOOKUP     = 3'd2;
   localparam logic [2:0] OP_LOOKUP_REF = 3'd3;
   localparam logic [2:0] OP_REF        = 3'd4;
   localparam logic [2:0] OP_CLOSE      = 3'd5;
   localparam logic [2:0] OP_DUP_MIN    = 3'd6;
   localparam logic [2:0] OP_DUP_TO     = 3'd7;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_BADF   = 3'd1;
   localparam logic [2:0] ST_BUSY   = 3'd2;
   localparam logic [2:0] ST_INVAL  = 3'd3;
   localparam logic [2:0] ST_NOFREE = 3'd4;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [8:0]  slot_index;
      logic [8:0]  second_index;
      logic [7:0]  object_id;
      logic [15:0] initial_count;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] result_slot;
      logic [7:0] result_object;
      logic       released;
   } rsp_type;

endpackage

[hdl/descriptor_table_allocator_core.sv]
`timescale 1ns / 1ps
// Descriptor table allocator core: slot table, occupancy bitmap, free hint
// and per-object reference counts behind a start/busy command interface.
// Depends on dta_pkg.

// A transaction is taken when start is high and busy is low; exactly one
// response follows, shown for one cycle on rsp_data with rsp_strobe high,
// and it cannot be held off. Lookup, ref and close pass through the read,
// check, fetch and evaluate states to a registered response; install and
// dup_to_slot add a commit state plus the hint update. Allocation and
// dup_from_min search the occupancy bitmap one 64-bit word per cycle. An
// allocation that finds no free slot from the hint retries from the reserved
// floor, and a new slot at or above the hint starts a further scan to move
// the free hint past it. The bitmap clears at reset, so no clearing pass is
// needed before the first transaction.
module descriptor_table_allocator_core
   import dta_pkg::*;
#(
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int OBJECT_COUNT = OBJECT_COUNT_DEF,
   parameter int RESERVED_LOW = RESERVED_LOW_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int SW        = $clog2(SLOT_COUNT);
   localparam int PW        = SW + 1;
   localparam int MAP_WORDS = (SLOT_COUNT + MAP_BITS - 1) / MAP_BITS;
   localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int OW        = $clog2(OBJECT_COUNT);
   localparam logic [PW-1:0] SLOT_LIMIT = PW'(SLOT_COUNT);
   localparam logic [PW-1:0] LOW_FLOOR  = PW'(RESERVED_LOW);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_CHECK, S_FETCH, S_EVAL, S_SCAN, S_COMMIT
   } state_type;

   typedef enum logic [1:0] {P_ALLOC, P_RETRY, P_DUP, P_HINT} purpose_type;

   state_type         state_ff;
   purpose_type       purpose_ff;
   req_type           req_ff;
   logic [7:0]        cur_ff;
   logic [7:0]        slot_rd_ff;
   logic [15:0]       count_rd_ff;
   logic [SW-1:0]     target_ff;
   logic [SW-1:0]     hint_ff;
   logic              hint_none_ff;
   logic [PW-1:0]     scan_lo_ff;
   logic [WW-1:0]     scan_word_ff;
   logic              rsp_strobe_ff;
   rsp_type           rsp_ff;
   logic [MAP_BITS-1:0] used_ff [MAP_WORDS];

   logic [7:0]  slot_mem  [SLOT_COUNT];
   logic [15:0] count_mem [OBJECT_COUNT];

   logic          si_ok, si_used, si2_ok, si2_used, obj_ok;
   logic [15:0]   cnt_inc;
   logic          slot_we, count_we, used_set, used_clr;
   logic [SW-1:0] slot_waddr, used_addr;
   logic [7:0]    slot_wdata;
   logic [OW-1:0] count_waddr;
   logic [15:0]   count_wdata;
   logic [MAP_BITS-1:0] open_bits;
   logic [5:0]    hit;
   logic          found, lo_over, last_word;
   logic [SW-1:0] found_slot;

   function automatic rsp_type make_rsp(input logic [2:0] status,
                                        input logic [7:0] slot,
                                        input logic [7:0] obj,
                                        input logic rel);
      rsp_type r;
      r.status        = status;
      r.result_slot   = slot;
      r.result_object = obj;
      r.released      = rel;
      return r;
   endfunction

   function automatic logic [WW-1:0] word_of(input logic [PW-1:0] lo);
      return (lo >= SLOT_LIMIT) ? '0 : WW'(lo >> 6);
   endfunction

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign si_ok    = 32'(req_ff.slot_index) < 32'(SLOT_COUNT);
   assign si2_ok   = 32'(req_ff.second_index) < 32'(SLOT_COUNT);
   assign obj_ok   = 32'(req_ff.object_id) < 32'(OBJECT_COUNT);
   assign si_used  = si_ok &&
                     used_ff[WW'(req_ff.slot_index >> 6)][req_ff.slot_index[5:0]];
   assign si2_used = si2_ok &&
                     used_ff[WW'(req_ff.second_index >> 6)][req_ff.second_index[5:0]];
   assign cnt_inc  = (count_rd_ff == COUNT_MAX) ? count_rd_ff : count_rd_ff + 16'd1;

   // One bitmap word per cycle: free bits at or above the search floor and
   // below the table end, lowest one wins.
   always_comb begin
      logic first_word;
      first_word = (scan_word_ff == word_of(scan_lo_ff));
      lo_over    = (scan_lo_ff >= SLOT_LIMIT);
      last_word  = (32'(scan_word_ff) == 32'(MAP_WORDS - 1));
      for (int b = 0; b < MAP_BITS; b++) begin
         open_bits[b] = !used_ff[scan_word_ff][b] &&
                        (!first_word || (b >= int'(scan_lo_ff[5:0]))) &&
                        ((32'(scan_word_ff) * 32'(MAP_BITS) + 32'(b)) < 32'(SLOT_COUNT));
      end
      hit = '0;
      for (int b = MAP_BITS - 1; b >= 0; b--) begin
         if (open_bits[b]) begin
            hit = 6'(b);
         end
      end
      found      = (|open_bits) && !lo_over;
      found_slot = SW'({scan_word_ff, hit});
   end

   always_comb begin
      slot_we     = 1'b0;
      slot_waddr  = target_ff;
      slot_wdata  = (req_ff.opcode == OP_ALLOC || req_ff.opcode == OP_INSTALL) ?
                    req_ff.object_id : cur_ff;
      count_we    = 1'b0;
      count_waddr = OW'(cur_ff);
      count_wdata = cnt_inc;
      used_set    = 1'b0;
      used_clr    = 1'b0;
      used_addr   = target_ff;
      unique case (state_ff)
         S_EVAL: begin
            if (cur_ff != 8'd0) begin
               if (req_ff.opcode == OP_LOOKUP_REF || req_ff.opcode == OP_REF) begin
                  count_we = 1'b1;
               end else if (req_ff.opcode == OP_CLOSE) begin
                  count_we = 1'b1;
                  if (count_rd_ff > 16'd1) begin
                     count_wdata = count_rd_ff - 16'd1;
                  end else begin
                     count_wdata = '0;
                     used_clr    = 1'b1;
                     used_addr   = SW'(req_ff.slot_index);
                  end
               end
            end
         end
         S_COMMIT: begin
            slot_we  = 1'b1;
            used_set = 1'b1;
            count_we = 1'b1;
            if (req_ff.opcode == OP_ALLOC || req_ff.opcode == OP_INSTALL) begin
               count_waddr = OW'(req_ff.object_id);
               count_wdata = req_ff.initial_count;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[SW'(req_ff.slot_index)];
   end

   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[count_waddr] <= count_wdata;
      end
      count_rd_ff <= count_mem[OW'(cur_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < MAP_WORDS; w++) begin
            used_ff[w] <= '0;
         end
      end else if (used_set) begin
         used_ff[WW'(used_addr >> 6)][used_addr[5:0]] <= 1'b1;
      end else if (used_clr) begin
         used_ff[WW'(used_addr >> 6)][used_addr[5:0]] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      state_type state_in;
      rsp_type   rsp_in;
      logic      rsp_strobe_in;
      state_in      = state_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      if (reset) begin
         state_ff      <= S_IDLE;
         purpose_ff    <= P_ALLOC;
         hint_ff       <= SW'(RESERVED_LOW);
         hint_none_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  state_in = S_READ;
               end
            end
            S_READ: begin
               state_in = S_CHECK;
            end
            S_CHECK: begin
               cur_ff   <= si_used ? slot_rd_ff : 8'd0;
               state_in = S_FETCH;
            end
            S_FETCH: begin
               state_in = S_EVAL;
            end
            S_EVAL: begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_in        = make_rsp(ST_OK, 8'd0, 8'd0, 1'b0);
               unique case (req_ff.opcode)
                  OP_ALLOC: begin
                     if (req_ff.object_id == 8'd0 || !obj_ok) begin
                        rsp_in = make_rsp(ST_INVAL, 8'd0, 8'd0, 1'b0);
                     end else begin
                        rsp_strobe_in = 1'b0;
                        state_in      = S_SCAN;
                        if (!hint_none_ff) begin
                           scan_lo_ff   <= PW'(hint_ff);
                           scan_word_ff <= word_of(PW'(hint_ff));
                           purpose_ff   <= P_ALLOC;
                        end else begin
                           scan_lo_ff   <= LOW_FLOOR;
                           scan_word_ff <= word_of(LOW_FLOOR);
                           purpose_ff   <= P_RETRY;
                        end
                     end
                  end
                  OP_INSTALL: begin
                     if (!si_ok || req_ff.object_id == 8'd0) begin
                        rsp_in = make_rsp(ST_BADF, 8'd0, 8'd0, 1'b0);
                     end else if (!obj_ok) begin
                        rsp_in = make_rsp(ST_INVAL, 8'd0, 8'd0, 1'b0);
                     end else if (si_used) begin
                        rsp_in = make_rsp(ST_BUSY, 8'd0, 8'd0, 1'b0);
                     end else begin
                        rsp_strobe_in = 1'b0;
                        target_ff     <= SW'(req_ff.slot_index);
                        state_in      = S_COMMIT;
                     end
                  end
                  OP_LOOKUP, OP_LOOKUP_REF: begin
                     if (cur_ff == 8'd0) begin
                        rsp_in = make_rsp(ST_BADF, 8'd0, 8'd0, 1'b0);
                     end else begin
                        rsp_in = make_rsp(ST_OK, 8'd0, cur_ff, 1'b0);
                     end
                  end
                  OP_REF: begin
                     if (cur_ff == 8'd0) begin
                        rsp_in = make_rsp(ST_BADF, 8'd0, 8'd0, 1'b0);
                     end
                  end
                  OP_CLOSE: begin
                     if (cur_ff == 8'd0) begin
                        rsp_in = make_rsp(ST_BADF, 8'd0, 8'd0, 1'b0);
                     end else if (count_rd_ff <= 16'd1) begin
                        rsp_in = make_rsp(ST_OK, 8'd0, cur_ff, 1'b1);
                        // A slot freed below the hint, or with no hint, becomes the hint.
                        if (hint_none_ff || (SW'(req_ff.slot_index) < hint_ff)) begin
                           hint_ff      <= SW'(req_ff.slot_index);
                           hint_none_ff <= 1'b0;
                        end
                     end
                  end
                  OP_DUP_MIN: begin
                     if (cur_ff == 8'd0) begin
                        rsp_in = make_rsp(ST_BADF, 8'd0, 8'd0, 1'b0);
                     end else if (!si2_ok) begin
                        rsp_in = make_rsp(ST_NOFREE, 8'd0, 8'd0, 1'b0);
                     end else begin
                        rsp_strobe_in = 1'b0;
                        state_in      = S_SCAN;
                        scan_lo_ff    <= PW'(req_ff.second_index);
                        scan_word_ff  <= word_of(PW'(req_ff.second_index));
                        purpose_ff    <= P_DUP;
                     end
                  end
                  OP_DUP_TO: begin
                     if (!si2_ok) begin
                        rsp_in = make_rsp(ST_BADF, 8'd0, 8'd0, 1'b0);
                     end else if (req_ff.slot_index == req_ff.second_index) begin
                        rsp_in = make_rsp(ST_INVAL, 8'd0, 8'd0, 1'b0);
                     end else if (cur_ff == 8'd0) begin
                        rsp_in = make_rsp(ST_BADF, 8'd0, 8'd0, 1'b0);
                     end else if (si2_used) begin
                        rsp_in = make_rsp(ST_BUSY, 8'd0, 8'd0, 1'b0);
                     end else begin
                        rsp_strobe_in = 1'b0;
                        target_ff     <= SW'(req_ff.second_index);
                        state_in      = S_COMMIT;
                     end
                  end
               endcase
            end
            S_SCAN: begin
               if (found) begin
                  if (purpose_ff == P_HINT) begin
                     hint_ff       <= found_slot;
                     hint_none_ff  <= 1'b0;
                     rsp_strobe_in = 1'b1;
                     rsp_in        = make_rsp(ST_OK, 8'(target_ff), 8'd0, 1'b0);
                     state_in      = S_IDLE;
                  end else begin
                     target_ff <= found_slot;
                     state_in  = S_COMMIT;
                  end
               end else if (lo_over || last_word) begin
                  unique case (purpose_ff)
                     P_ALLOC: begin
                        scan_lo_ff   <= LOW_FLOOR;
                        scan_word_ff <= word_of(LOW_FLOOR);
                        purpose_ff   <= P_RETRY;
                     end
                     P_RETRY, P_DUP: begin
                        rsp_strobe_in = 1'b1;
                        rsp_in        = make_rsp(ST_NOFREE, 8'd0, 8'd0, 1'b0);
                        state_in      = S_IDLE;
                     end
                     P_HINT: begin
                        hint_none_ff  <= 1'b1;
                        rsp_strobe_in = 1'b1;
                        rsp_in        = make_rsp(ST_OK, 8'(target_ff), 8'd0, 1'b0);
                        state_in      = S_IDLE;
                     end
                  endcase
               end else begin
                  scan_word_ff <= scan_word_ff + WW'(1);
               end
            end
            S_COMMIT: begin
               // Taking a slot at or above the hint pushes the hint past it.
               if (hint_none_ff || (target_ff >= hint_ff)) begin
                  scan_lo_ff   <= PW'(target_ff) + PW'(1);
                  scan_word_ff <= word_of(PW'(target_ff) + PW'(1));
                  purpose_ff   <= P_HINT;
                  state_in     = S_SCAN;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = make_rsp(ST_OK, 8'(target_ff), 8'd0, 1'b0);
                  state_in      = S_IDLE;
               end
            end
         endcase
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ff        <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("more than one response for a transaction");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in progress");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.released |->
         rsp_data.status == ST_OK && rsp_data.result_object != 8'd0)
      else $error("release reported without a freed object");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |->
         rsp_data.result_slot == 8'd0 && !rsp_data.released)
      else $error("failed transaction reported a slot or a release");
`endif

endmodule
